FILE: rtl/s5hp_pkg.sv
`timescale 1ns / 1ps
// Shared types, protocol codes and helpers for the SOCKS5 handshake parser.
// No dependencies; used by every module in rtl/.
package s5hp_pkg;

    localparam logic [7:0] SOCKS_VER      = 8'd5;
    localparam logic [7:0] METHOD_NONE    = 8'd0;
    localparam logic [7:0] METHOD_REFUSED = 8'd255;
    localparam logic [7:0] CMD_CONNECT    = 8'd1;
    localparam logic [7:0] RSV_ZERO       = 8'd0;
    localparam logic [7:0] ATYP_IPV4      = 8'd1;
    localparam logic [7:0] ATYP_HOST      = 8'd3;
    localparam logic [7:0] ATYP_IPV6      = 8'd4;
    localparam logic [7:0] LEN_IPV4       = 8'd4;
    localparam logic [7:0] LEN_IPV6       = 8'd16;

    localparam logic [1:0] EV_REPLY    = 2'd0;
    localparam logic [1:0] EV_ADDR     = 2'd1;
    localparam logic [1:0] EV_COMPLETE = 2'd2;
    localparam logic [1:0] EV_ABORT    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FAIL   = 2'd1;
    localparam logic [1:0] ST_NO_CMD = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [10:0] {
        PH_GVER  = 11'b000_0000_0001,
        PH_NMETH = 11'b000_0000_0010,
        PH_METH  = 11'b000_0000_0100,
        PH_RVER  = 11'b000_0000_1000,
        PH_CMD   = 11'b000_0001_0000,
        PH_RSV   = 11'b000_0010_0000,
        PH_ATYP  = 11'b000_0100_0000,
        PH_HLEN  = 11'b000_1000_0000,
        PH_ADDR  = 11'b001_0000_0000,
        PH_PORT  = 11'b010_0000_0000,
        PH_IDLE  = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0]  req_status;
        logic [15:0] port;
        logic [7:0]  addr_type;
        logic [7:0]  command;
        logic [7:0]  addr_span;
        logic [7:0]  addr_index;
        logic [7:0]  data;
    } t_payload;

    typedef struct packed {
        logic       last;
        logic [1:0] event_res;
        t_payload   pl;
    } t_result;

    typedef struct packed {
        t_result    res0;
        t_result    res1;
        logic [1:0] num;
    } t_emit;

    function automatic t_result mk_result(input logic [1:0] ev, input logic [7:0] dat,
                                          input logic [7:0] idx, input logic [7:0] len,
                                          input logic lst);
        t_result r;
        r = '0;
        r.event_res     = ev;
        r.pl.data       = dat;
        r.pl.addr_index = idx;
        r.pl.addr_span  = len;
        r.last          = lst;
        return r;
    endfunction

    function automatic logic [7:0] field_len(input logic [7:0] atyp, input logic [7:0] hlen);
        logic [7:0] l;
        l = 8'd0;
        if (atyp == ATYP_IPV4) begin
            l = LEN_IPV4;
        end else if (atyp == ATYP_IPV6) begin
            l = LEN_IPV6;
        end else if (atyp == ATYP_HOST) begin
            l = hlen;
        end
        return l;
    endfunction

endpackage

FILE: rtl/s5hp_core.sv
`timescale 1ns / 1ps
// Handshake state machine: consumes one registered byte and produces up to
// two result items. Depends on s5hp_pkg.
module s5hp_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [7:0]      i_byte,
    input  logic            i_start,
    output s5hp_pkg::t_emit o_emit
);

    s5hp_pkg::t_phase r_phase, n_phase, c_phase;
    logic [8:0]  r_byte_count, n_byte_count, c_byte_count;
    logic [7:0]  r_methods_left, n_methods_left, c_methods_left;
    logic        r_no_auth_seen, n_no_auth_seen, c_no_auth_seen;
    logic [7:0]  r_command_held, n_command_held, c_command_held;
    logic [7:0]  r_type_held, n_type_held, c_type_held;
    logic [7:0]  r_host_length, n_host_length, c_host_length;
    logic [15:0] r_port_held, n_port_held, c_port_held;
    logic [1:0]  r_status_held, n_status_held, c_status_held;
    logic [8:0]  w_cnt_inc;
    logic [7:0]  w_len;
    s5hp_pkg::t_emit w_emit;
    s5hp_pkg::t_result w_done;

    always_comb begin
        if (i_start) begin
            c_phase        = s5hp_pkg::PH_GVER;
            c_byte_count   = '0;
            c_methods_left = '0;
            c_no_auth_seen = 1'b0;
            c_command_held = '0;
            c_type_held    = '0;
            c_host_length  = '0;
            c_port_held    = '0;
            c_status_held  = '0;
        end else begin
            c_phase        = r_phase;
            c_byte_count   = r_byte_count;
            c_methods_left = r_methods_left;
            c_no_auth_seen = r_no_auth_seen;
            c_command_held = r_command_held;
            c_type_held    = r_type_held;
            c_host_length  = r_host_length;
            c_port_held    = r_port_held;
            c_status_held  = r_status_held;
        end
    end

    always_comb begin
        n_phase        = c_phase;
        n_byte_count   = c_byte_count;
        n_methods_left = c_methods_left;
        n_no_auth_seen = c_no_auth_seen;
        n_command_held = c_command_held;
        n_type_held    = c_type_held;
        n_host_length  = c_host_length;
        n_port_held    = c_port_held;
        n_status_held  = c_status_held;
        w_emit         = '0;
        w_cnt_inc      = c_byte_count + 9'd1;
        w_len          = s5hp_pkg::field_len(c_type_held, c_host_length);
        w_done         = '0;
        unique case (c_phase)
            s5hp_pkg::PH_GVER: begin
                if (i_byte != s5hp_pkg::SOCKS_VER) begin
                    n_phase     = s5hp_pkg::PH_IDLE;
                    w_emit.res0 = s5hp_pkg::mk_result(s5hp_pkg::EV_ABORT, 8'd0, 8'd0, 8'd0,
                                                      1'b1);
                    w_emit.num  = 2'd1;
                end else begin
                    n_phase = s5hp_pkg::PH_NMETH;
                end
            end
            s5hp_pkg::PH_NMETH: begin
                n_no_auth_seen = 1'b0;
                n_methods_left = i_byte;
                if (i_byte == 8'd0) begin
                    w_emit.res0 = s5hp_pkg::mk_result(s5hp_pkg::EV_REPLY, s5hp_pkg::SOCKS_VER,
                                                      8'd0, 8'd0, 1'b0);
                    w_emit.res1 = s5hp_pkg::mk_result(s5hp_pkg::EV_REPLY,
                                                      s5hp_pkg::METHOD_REFUSED, 8'd0, 8'd0,
                                                      1'b1);
                    w_emit.num  = 2'd2;
                    n_phase     = s5hp_pkg::PH_IDLE;
                end else begin
                    n_phase = s5hp_pkg::PH_METH;
                end
            end
            s5hp_pkg::PH_METH: begin
                n_no_auth_seen = c_no_auth_seen | (i_byte == s5hp_pkg::METHOD_NONE);
                n_methods_left = c_methods_left - 8'd1;
                if (n_methods_left == 8'd0) begin
                    w_emit.res0 = s5hp_pkg::mk_result(s5hp_pkg::EV_REPLY, s5hp_pkg::SOCKS_VER,
                                                      8'd0, 8'd0, 1'b0);
                    w_emit.res1 = s5hp_pkg::mk_result(s5hp_pkg::EV_REPLY,
                                                      n_no_auth_seen ? s5hp_pkg::METHOD_NONE
                                                                     : s5hp_pkg::METHOD_REFUSED,
                                                      8'd0, 8'd0, 1'b1);
                    w_emit.num  = 2'd2;
                    n_phase     = n_no_auth_seen ? s5hp_pkg::PH_RVER : s5hp_pkg::PH_IDLE;
                end
            end
            s5hp_pkg::PH_RVER: begin
                if (i_byte != s5hp_pkg::SOCKS_VER) begin
                    n_phase     = s5hp_pkg::PH_IDLE;
                    w_emit.res0 = s5hp_pkg::mk_result(s5hp_pkg::EV_ABORT, 8'd0, 8'd0, 8'd0,
                                                      1'b1);
                    w_emit.num  = 2'd1;
                end else begin
                    n_status_held = s5hp_pkg::ST_OK;
                    n_phase       = s5hp_pkg::PH_CMD;
                end
            end
            s5hp_pkg::PH_CMD: begin
                n_command_held = i_byte;
                if (i_byte != s5hp_pkg::CMD_CONNECT) begin
                    n_status_held = s5hp_pkg::ST_NO_CMD;
                end
                n_phase = s5hp_pkg::PH_RSV;
            end
            s5hp_pkg::PH_RSV: begin
                if (i_byte != s5hp_pkg::RSV_ZERO) begin
                    n_status_held = s5hp_pkg::ST_FAIL;
                end
                n_phase = s5hp_pkg::PH_ATYP;
            end
            s5hp_pkg::PH_ATYP: begin
                n_type_held  = i_byte;
                n_byte_count = '0;
                if (i_byte == s5hp_pkg::ATYP_IPV4 || i_byte == s5hp_pkg::ATYP_IPV6) begin
                    n_phase = s5hp_pkg::PH_ADDR;
                end else if (i_byte == s5hp_pkg::ATYP_HOST) begin
                    n_phase = s5hp_pkg::PH_HLEN;
                end else begin
                    n_status_held        = s5hp_pkg::ST_FAIL;
                    n_port_held          = '0;
                    w_done               = s5hp_pkg::mk_result(s5hp_pkg::EV_COMPLETE, 8'd0,
                                                               8'd0, 8'd0, 1'b1);
                    w_done.pl.command    = c_command_held;
                    w_done.pl.addr_type  = i_byte;
                    w_done.pl.port       = '0;
                    w_done.pl.req_status = s5hp_pkg::ST_FAIL;
                    w_emit.res0          = w_done;
                    w_emit.num           = 2'd1;
                    n_phase              = s5hp_pkg::PH_IDLE;
                end
            end
            s5hp_pkg::PH_HLEN: begin
                n_host_length = i_byte;
                n_byte_count  = '0;
                n_phase       = (i_byte == 8'd0) ? s5hp_pkg::PH_PORT : s5hp_pkg::PH_ADDR;
            end
            s5hp_pkg::PH_ADDR: begin
                w_emit.res0 = s5hp_pkg::mk_result(s5hp_pkg::EV_ADDR, i_byte,
                                                  c_byte_count[7:0], w_len, 1'b1);
                w_emit.num  = 2'd1;
                if (w_cnt_inc >= {1'b0, w_len}) begin
                    n_byte_count = '0;
                    n_phase      = s5hp_pkg::PH_PORT;
                end else begin
                    n_byte_count = w_cnt_inc;
                end
            end
            s5hp_pkg::PH_PORT: begin
                if (c_byte_count == 9'd0) begin
                    n_port_held  = {i_byte, 8'd0};
                    n_byte_count = 9'd1;
                end else begin
                    n_port_held          = {c_port_held[15:8], i_byte};
                    n_byte_count         = '0;
                    w_done               = s5hp_pkg::mk_result(s5hp_pkg::EV_COMPLETE, 8'd0,
                                                               8'd0, w_len, 1'b1);
                    w_done.pl.command    = c_command_held;
                    w_done.pl.addr_type  = c_type_held;
                    w_done.pl.port       = {c_port_held[15:8], i_byte};
                    w_done.pl.req_status = c_status_held;
                    w_emit.res0          = w_done;
                    w_emit.num           = 2'd1;
                    n_phase              = s5hp_pkg::PH_IDLE;
                end
            end
            s5hp_pkg::PH_IDLE: begin
                n_phase = s5hp_pkg::PH_IDLE;
            end
            default: begin
                n_phase = s5hp_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= s5hp_pkg::PH_GVER;
            r_byte_count   <= '0;
            r_methods_left <= '0;
            r_no_auth_seen <= 1'b0;
            r_command_held <= '0;
            r_type_held    <= '0;
            r_host_length  <= '0;
            r_port_held    <= '0;
            r_status_held  <= '0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_methods_left <= n_methods_left;
            r_no_auth_seen <= n_no_auth_seen;
            r_command_held <= n_command_held;
            r_type_held    <= n_type_held;
            r_host_length  <= n_host_length;
            r_port_held    <= n_port_held;
            r_status_held  <= n_status_held;
        end
    end

    assign o_emit = w_emit;

endmodule

FILE: rtl/s5hp_result_queue.sv
`timescale 1ns / 1ps
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on s5hp_pkg.
module s5hp_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  s5hp_pkg::t_emit   i_emit,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_pop,
    output s5hp_pkg::t_result o_head
);

    s5hp_pkg::t_result r_mem [s5hp_pkg::QDEPTH];
    logic [s5hp_pkg::QAW-1:0] r_wptr, n_wptr, r_rptr;
    logic [s5hp_pkg::QAW:0]   r_count, n_count, w_after_pop;
    logic                     w_pop;
    logic [1:0]               w_num;

    assign w_pop       = i_pop && (r_count != '0);
    assign w_after_pop = r_count - {{s5hp_pkg::QAW{1'b0}}, w_pop};
    assign o_room      = w_after_pop <= (s5hp_pkg::QAW + 1)'(s5hp_pkg::QDEPTH - 2);
    assign w_num       = i_push ? i_emit.num : 2'd0;
    assign n_wptr      = r_wptr + s5hp_pkg::QAW'(w_num);
    assign n_count     = w_after_pop + (s5hp_pkg::QAW + 1)'(w_num);

    always_ff @(posedge i_clk) begin
        if (w_num != 2'd0) begin
            r_mem[r_wptr] <= i_emit.res0;
        end
        if (w_num == 2'd2) begin
            r_mem[r_wptr + s5hp_pkg::QAW'(1)] <= i_emit.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_count <= n_count;
            if (w_pop) begin
                r_rptr <= r_rptr + s5hp_pkg::QAW'(1);
            end
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rptr];

endmodule

FILE: rtl/socks5_handshake_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the SOCKS5 server handshake parser.
// Depends on s5hp_pkg, s5hp_core and s5hp_result_queue.
//
// Usage:
//   Slave channel: one client byte per transaction on s_axis_tdata; s_axis_tuser
//   is high on the first byte of a new connection and clears all parse state.
//   Master channel: result items. m_axis_tuser carries the event kind (reply
//   byte, address byte, request complete, protocol abort); m_axis_tlast marks
//   the last result caused by one input byte.
//   Datapath: a byte in the input register is parsed combinationally by the
//   core and its results are written into the result queue, which offers them
//   on m_axis. Throughput: one byte per cycle while the queue has room; the
//   single output port hands out results one at a time, so bytes that produce
//   two results (the method reply) are absorbed by the four-entry result queue.
//   Reset (i_rst_n low, synchronous): parser returns to the greeting version
//   state, input register and queue empty.
//   Stall: when m_axis_tready is low the queue fills; s_axis_tready drops while
//   a byte waits in the input register and the queue cannot take two more
//   results, and no result is lost.
module socks5_handshake_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] conn_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] data, [15:8] addr_index, [23:16] addr_span,
                                        // [31:24] command, [39:32] addr_type,
                                        // [55:40] port, [57:56] req_status, [63:58] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] event_res
    output logic        m_axis_tlast
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_start;
    logic              w_room;
    logic              w_proc;
    s5hp_pkg::t_emit   w_emit;
    s5hp_pkg::t_result w_head;

    assign w_proc        = r_in_valid && w_room;
    assign s_axis_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    s5hp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_proc),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .o_emit  (w_emit)
    );

    s5hp_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_proc),
        .i_emit  (w_emit),
        .o_room  (w_room),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_head  (w_head)
    );

    assign m_axis_tdata = {6'd0, w_head.pl};
    assign m_axis_tuser = w_head.event_res;
    assign m_axis_tlast = w_head.last;

endmodule
